@@ rtl/mms_pkg.sv @@
// Package for the motor mixer: codes, widths, the mixing coefficient tables
// and small helper functions. Depends on nothing.
`default_nettype none

package mms_pkg;

  localparam int MAX_MOTORS   = 16;
  localparam int NUM_CONTROLS = 6;
  localparam int MOTOR_IDX_W  = $clog2(MAX_MOTORS);
  localparam int CTRL_W       = 17;
  localparam int LEVEL_W      = 16;
  localparam int FULL_LEVEL   = 32768;
  localparam int LIMIT_NEG_UNBOUNDED = -65536;
  localparam int LIMIT_POS_UNBOUNDED = 65535;
  localparam int DIRECT_MOTORS  = 6;
  localparam int AIRSHIP_MOTORS = 16;

  // Layout register codes.
  localparam logic [1:0] LAYOUT_NONE    = 2'd0;
  localparam logic [1:0] LAYOUT_DIRECT  = 2'd1;
  localparam logic [1:0] LAYOUT_AIRSHIP = 2'd2;

  // Command kinds.
  localparam logic [1:0] KIND_MIX   = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOCFG  = 2'd1;
  localparam logic [1:0] ST_BADCH  = 2'd2;

  // First legal channel of each layout; the last legal one is NUM_CONTROLS-1.
  localparam logic [2:0] DIRECT_MIN_CH  = 3'd2;
  localparam logic [2:0] AIRSHIP_MIN_CH = 3'd0;
  localparam logic [2:0] LAST_CH        = 3'(NUM_CONTROLS - 1);

  typedef enum logic [1:0] {
    ALU_MIX,
    ALU_ADD,
    ALU_CHECK
  } alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOTOR,
    S_ERROR
  } state_t;

  // One matrix row: bit j of pos is a +1 on control j, bit j of neg a -1.
  // Control order from bit 0: X, Y, Z, roll, pitch, yaw.
  typedef struct packed {
    logic [NUM_CONTROLS-1:0] pos;
    logic [NUM_CONTROLS-1:0] neg;
  } coef_row_t;

  typedef struct packed {
    alu_op_t   op;
    logic [2:0] channel;
    coef_row_t row;
  } alu_ctl_t;

  function automatic coef_row_t coef_row(input logic [1:0] layout, input logic [3:0] row);
    coef_row_t r;
    r.pos = '0;
    r.neg = '0;
    if (layout == LAYOUT_DIRECT) begin
      case (row)
        4'd0: begin r.pos = 6'b001000; r.neg = 6'b000100; end
        4'd1: begin r.pos = 6'b000000; r.neg = 6'b001100; end
        4'd2: begin r.pos = 6'b010000; r.neg = 6'b000100; end
        4'd3: begin r.pos = 6'b000000; r.neg = 6'b010100; end
        4'd4: begin r.pos = 6'b100000; r.neg = 6'b000100; end
        4'd5: begin r.pos = 6'b000000; r.neg = 6'b100100; end
        default: begin r.pos = '0; r.neg = '0; end
      endcase
    end else begin
      case (row[3:1])
        3'd0: begin r.pos = 6'b011000; r.neg = 6'b100100; end
        3'd1: begin r.pos = 6'b110000; r.neg = 6'b001100; end
        3'd2: begin r.pos = 6'b001000; r.neg = 6'b110100; end
        3'd3: begin r.pos = 6'b100000; r.neg = 6'b011100; end
        3'd4, 3'd5: begin r.pos = 6'b000001; r.neg = 6'b000000; end
        default: begin r.pos = 6'b000000; r.neg = 6'b000001; end
      endcase
    end
    return r;
  endfunction

  // Index of the highest motor that a layout drives.
  function automatic logic [MOTOR_IDX_W-1:0] motor_last(input logic [1:0] layout);
    int n;
    n = (layout == LAYOUT_DIRECT) ? DIRECT_MOTORS : AIRSHIP_MOTORS;
    if (n > MAX_MOTORS) n = MAX_MOTORS;
    return MOTOR_IDX_W'(n - 1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/mms_levels.sv @@
// Motor level register file: one write and one read port, cleared on reset.
// Depends on mms_pkg.
`default_nettype none

module mms_levels
  import mms_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [MOTOR_IDX_W-1:0] addr,
  input  wire logic [LEVEL_W-1:0]     wr_data,
  output logic      [LEVEL_W-1:0]     rd_data
);

  logic [LEVEL_W-1:0] level_r [MAX_MOTORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MOTORS; i++) level_r[i] <= '0;
    end else if (wr_en) begin
      level_r[addr] <= wr_data;
    end
  end

  assign rd_data = level_r[addr];

endmodule

`default_nettype wire

@@ rtl/mms_alu.sv @@
// Shared per-motor arithmetic unit: mix sum, single-channel add with clamp,
// and the saturation limit update for one motor. Depends on mms_pkg.
`default_nettype none

module mms_alu
  import mms_pkg::*;
(
  input  wire alu_ctl_t           ctl,
  input  wire logic signed [CTRL_W-1:0] ctrl [NUM_CONTROLS],
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic signed [CTRL_W-1:0] lo_in,
  input  wire logic signed [CTRL_W-1:0] hi_in,
  output logic [LEVEL_W-1:0]      level_new,
  output logic signed [CTRL_W-1:0] lo_out,
  output logic signed [CTRL_W-1:0] hi_out
);

  localparam logic signed [19:0] FULL_S20 = 20'(FULL_LEVEL);
  localparam logic signed [17:0] FULL_S18 = 18'(FULL_LEVEL);

  logic signed [19:0] mix_sum;
  logic signed [19:0] add_sum;
  logic signed [19:0] pre;
  logic signed [CTRL_W-1:0] addv;
  logic signed [17:0] m;
  logic signed [17:0] up;
  logic signed [17:0] dn;
  logic pos_c;
  logic neg_c;

  always_comb begin
    mix_sum = '0;
    for (int j = 0; j < NUM_CONTROLS; j++) begin
      if (ctl.row.pos[j])      mix_sum = mix_sum + 20'(ctrl[j]);
      else if (ctl.row.neg[j]) mix_sum = mix_sum - 20'(ctrl[j]);
    end
  end

  assign addv  = ctrl[ctl.channel];
  assign pos_c = ctl.row.pos[ctl.channel];
  assign neg_c = ctl.row.neg[ctl.channel];

  always_comb begin
    add_sum = $signed({4'b0000, level});
    if (pos_c)      add_sum = add_sum + 20'(addv);
    else if (neg_c) add_sum = add_sum - 20'(addv);
  end

  always_comb begin
    pre = (ctl.op == ALU_MIX) ? mix_sum : add_sum;
    if (pre < 20'sd0)         level_new = '0;
    else if (pre > FULL_S20)  level_new = LEVEL_W'(FULL_LEVEL);
    else                      level_new = pre[LEVEL_W-1:0];
  end

  // Headroom of this motor on the selected channel, both directions.
  always_comb begin
    m = $signed({2'b00, level});
    if (pos_c) begin
      up = FULL_S18 - m;
      dn = -m;
    end else begin
      up = m;
      dn = m - FULL_S18;
    end
    lo_out = lo_in;
    hi_out = hi_in;
    if (pos_c || neg_c) begin
      if (up < 18'(hi_in)) hi_out = up[CTRL_W-1:0];
      if (dn > 18'(lo_in)) lo_out = dn[CTRL_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/motor_mixer_with_saturation_unit.sv @@
// Top level of the motor mixer: command port, layout register, sequencer and
// result register. Depends on mms_pkg, mms_levels and mms_alu.
`default_nettype none

// A command is taken at a clock edge with start high and busy low. Mix and add
// walk the motors of the layout one per cycle through a single shared
// arithmetic unit and the motor level file, busy staying high until the last
// motor is done; check walks the same motors to narrow the safe range and
// then gives one result. An error (layout not configured or channel out of
// range) keeps busy for one cycle. Kind 3 is taken and ignored and leaves busy
// low. Every result is shown on the out_ ports for exactly one cycle with
// out_strobe high, the first one once the sequencer state and then the result
// registers have been loaded; there is no way to hold results off, so the
// receiver must take each one in the cycle it appears. The next command may
// be issued in the cycle that carries the previous last result. The user must
// write the layout through cfg_we/cfg_data only while no command is in flight;
// the block does not enforce it. Motor levels are kept across layout changes.

module motor_mixer_with_saturation_unit
  import mms_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_data,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_kind,
  input  wire logic [2:0]               in_channel,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_x,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_y,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_z,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_roll,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_pitch,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_yaw,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [3:0]                    out_motor_index,
  output logic [LEVEL_W-1:0]            out_motor_value,
  output logic signed [CTRL_W-1:0]      out_limit_low,
  output logic signed [CTRL_W-1:0]      out_limit_high,
  output logic                          out_last
);

  state_t state_r, state_nxt;
  logic [1:0] layout_r;
  logic [1:0] job_layout_r, job_layout_nxt;
  alu_op_t    op_r, op_nxt;
  logic [2:0] chan_r, chan_nxt;
  logic [MOTOR_IDX_W-1:0] idx_r, idx_nxt;
  logic [MOTOR_IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic signed [CTRL_W-1:0] lo_r, lo_nxt;
  logic signed [CTRL_W-1:0] hi_r, hi_nxt;
  logic [1:0] err_status_r, err_status_nxt;
  logic signed [CTRL_W-1:0] ctrl_r [NUM_CONTROLS];
  logic signed [CTRL_W-1:0] in_ctrl [NUM_CONTROLS];

  logic                          out_strobe_r, out_strobe_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [3:0]                    out_index_r, out_index_nxt;
  logic [LEVEL_W-1:0]            out_value_r, out_value_nxt;
  logic signed [CTRL_W-1:0]      out_lo_r, out_lo_nxt;
  logic signed [CTRL_W-1:0]      out_hi_r, out_hi_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                   accept;
  logic                   layout_ok;
  logic                   chan_ok;
  logic [2:0]             min_ch;
  logic                   lev_we;
  logic [LEVEL_W-1:0]     lev_rd;
  alu_ctl_t               alu_ctl;
  logic [LEVEL_W-1:0]     alu_level;
  logic signed [CTRL_W-1:0] alu_lo;
  logic signed [CTRL_W-1:0] alu_hi;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign in_ctrl[0] = in_ctrl_x;
  assign in_ctrl[1] = in_ctrl_y;
  assign in_ctrl[2] = in_ctrl_z;
  assign in_ctrl[3] = in_ctrl_roll;
  assign in_ctrl[4] = in_ctrl_pitch;
  assign in_ctrl[5] = in_ctrl_yaw;

  // A layout code of 3 behaves like an unconfigured layout.
  assign layout_ok = (layout_r == LAYOUT_DIRECT) || (layout_r == LAYOUT_AIRSHIP);
  assign min_ch    = (layout_r == LAYOUT_DIRECT) ? DIRECT_MIN_CH : AIRSHIP_MIN_CH;
  assign chan_ok   = (in_channel >= min_ch) && (in_channel <= LAST_CH);

  assign alu_ctl.op      = op_r;
  assign alu_ctl.channel = chan_r;
  assign alu_ctl.row     = coef_row(job_layout_r, 4'(idx_r));

  mms_levels u_levels (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lev_we),
    .addr    (idx_r),
    .wr_data (alu_level),
    .rd_data (lev_rd)
  );

  mms_alu u_alu (
    .ctl       (alu_ctl),
    .ctrl      (ctrl_r),
    .level     (lev_rd),
    .lo_in     (lo_r),
    .hi_in     (hi_r),
    .level_new (alu_level),
    .lo_out    (alu_lo),
    .hi_out    (alu_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      layout_r     <= LAYOUT_NONE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) layout_r <= cfg_data;
    end
  end

  // Job and result payload registers need no reset.
  always_ff @(posedge clk) begin
    job_layout_r <= job_layout_nxt;
    op_r         <= op_nxt;
    chan_r       <= chan_nxt;
    idx_r        <= idx_nxt;
    last_idx_r   <= last_idx_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    err_status_r <= err_status_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      for (int j = 0; j < NUM_CONTROLS; j++) ctrl_r[j] <= in_ctrl[j];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    job_layout_nxt = job_layout_r;
    op_nxt         = op_r;
    chan_nxt       = chan_r;
    idx_nxt        = idx_r;
    last_idx_nxt   = last_idx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    err_status_nxt = err_status_r;
    lev_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_MIX || in_kind == KIND_ADD ||
                       in_kind == KIND_CHECK)) begin
          if (!layout_ok) begin
            err_status_nxt = ST_NOCFG;
            state_nxt      = S_ERROR;
          end else if (in_kind != KIND_MIX && !chan_ok) begin
            err_status_nxt = ST_BADCH;
            state_nxt      = S_ERROR;
          end else begin
            case (in_kind)
              KIND_MIX: op_nxt = ALU_MIX;
              KIND_ADD: op_nxt = ALU_ADD;
              default:  op_nxt = ALU_CHECK;
            endcase
            job_layout_nxt = layout_r;
            chan_nxt       = in_channel;
            idx_nxt        = '0;
            last_idx_nxt   = motor_last(layout_r);
            lo_nxt         = CTRL_W'(LIMIT_NEG_UNBOUNDED);
            hi_nxt         = CTRL_W'(LIMIT_POS_UNBOUNDED);
            state_nxt      = S_MOTOR;
          end
        end
      end

      S_MOTOR: begin
        if (op_r == ALU_CHECK) begin
          lo_nxt = alu_lo;
          hi_nxt = alu_hi;
          if (idx_r == last_idx_r) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_OK;
            out_index_nxt  = '0;
            out_value_nxt  = '0;
            out_lo_nxt     = alu_lo;
            out_hi_nxt     = alu_hi;
            out_last_nxt   = 1'b1;
          end
        end else begin
          // One motor per cycle: store the clamped level and report it.
          lev_we         = 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_OK;
          out_index_nxt  = 4'(idx_r);
          out_value_nxt  = alu_level;
          out_lo_nxt     = '0;
          out_hi_nxt     = '0;
          out_last_nxt   = (idx_r == last_idx_r);
        end
        if (idx_r == last_idx_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_ERROR: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = err_status_r;
        out_index_nxt  = '0;
        out_value_nxt  = '0;
        out_lo_nxt     = '0;
        out_hi_nxt     = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_motor_index = out_index_r;
  assign out_motor_value = out_value_r;
  assign out_limit_low   = out_lo_r;
  assign out_limit_high  = out_hi_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  // No result can appear in the cycle right after a command transfer.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("result strobe right after command transfer");

  // An error is always a single, final result.
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> out_last)
    else $error("error result not marked last");

  // Stored levels are clamped, so a reported level never exceeds full scale.
  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_motor_value <= LEVEL_W'(FULL_LEVEL)))
    else $error("motor level above full scale");

  // The error state lasts one cycle and produces its result.
  a_error_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERROR) |=> (out_strobe && out_last && !busy))
    else $error("error state did not report");
`endif

endmodule

`default_nettype wire

@@ sim/motor_result_checker.sv @@
// Result checker for the motor mixer: keeps its own copy of the layout and the
// motor levels, predicts every result of each accepted command and compares.
// Depends on mms_pkg for widths, codes and motor counts.
`default_nettype none

module motor_result_checker
  import mms_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_data,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [1:0]               in_kind,
  input  wire logic [2:0]               in_channel,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_x,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_y,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_z,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_roll,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_pitch,
  input  wire logic signed [CTRL_W-1:0] in_ctrl_yaw,
  input  wire logic                     out_strobe,
  input  wire logic [1:0]               out_status,
  input  wire logic [3:0]               out_motor_index,
  input  wire logic [LEVEL_W-1:0]       out_motor_value,
  input  wire logic signed [CTRL_W-1:0] out_limit_low,
  input  wire logic signed [CTRL_W-1:0] out_limit_high,
  input  wire logic                     out_last,
  output int                            mismatches,
  output int                            pending_results,
  output int                            results_checked
);

  typedef struct packed {
    logic [1:0]               status;
    logic [3:0]               index;
    logic [LEVEL_W-1:0]       value;
    logic signed [CTRL_W-1:0] low;
    logic signed [CTRL_W-1:0] high;
    logic                     last;
  } motor_result_t;

  motor_result_t      expected_results[$];
  logic [1:0]         layout_copy;
  logic [LEVEL_W-1:0] level_copy [MAX_MOTORS];
  int                 mismatch_total;
  int                 checked_total;

  initial begin
    mismatch_total = 0;
    checked_total = 0;
    mismatches = 0;
    pending_results = 0;
    results_checked = 0;
  end

  // Mixing weight of control col on motor m: -1, 0 or +1.
  function automatic int mix_weight(input logic [1:0] layout, input int m, input int col);
    int w;
    w = 0;
    if (layout == LAYOUT_DIRECT) begin
      if (col == 2) w = -1;
      else if (col == 3 + m / 2) w = (m % 2 == 0) ? 1 : -1;
    end else if (m < 8) begin
      case (col)
        2: w = -1;
        3: w = ((m & 2) != 0) ? -1 : 1;
        4: w = ((m & 4) != 0) ? -1 : 1;
        5: w = ((m & 2) != 0) ? 1 : -1;
        default: w = 0;
      endcase
    end else if (col == 0) begin
      w = (m < 12) ? 1 : -1;
    end
    return w;
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_level(input int v);
    if (v < 0) return '0;
    if (v > FULL_LEVEL) return LEVEL_W'(FULL_LEVEL);
    return LEVEL_W'(v);
  endfunction

  task automatic push_result(input logic [1:0] status, input int idx, input int val,
                             input int lo, input int hi, input bit last);
    motor_result_t r;
    r.status = status;
    r.index = 4'(idx);
    r.value = LEVEL_W'(val);
    r.low = CTRL_W'(lo);
    r.high = CTRL_W'(hi);
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_command();
    int u [NUM_CONTROLS];
    int motors, i, j, s, w, m, lo, hi, ch;
    logic [2:0] first_ch;
    u[0] = in_ctrl_x;
    u[1] = in_ctrl_y;
    u[2] = in_ctrl_z;
    u[3] = in_ctrl_roll;
    u[4] = in_ctrl_pitch;
    u[5] = in_ctrl_yaw;
    ch = in_channel;
    motors = (layout_copy == LAYOUT_DIRECT) ? DIRECT_MOTORS : AIRSHIP_MOTORS;
    if (motors > MAX_MOTORS) motors = MAX_MOTORS;
    first_ch = (layout_copy == LAYOUT_DIRECT) ? DIRECT_MIN_CH : AIRSHIP_MIN_CH;
    if (in_kind != KIND_MIX && in_kind != KIND_ADD && in_kind != KIND_CHECK) begin
      // Unused kind: no result and no state change.
    end else if (layout_copy != LAYOUT_DIRECT && layout_copy != LAYOUT_AIRSHIP) begin
      push_result(ST_NOCFG, 0, 0, 0, 0, 1'b1);
    end else if (in_kind == KIND_MIX) begin
      for (i = 0; i < motors; i++) begin
        s = 0;
        for (j = 0; j < NUM_CONTROLS; j++) s += mix_weight(layout_copy, i, j) * u[j];
        level_copy[i] = clamp_level(s);
      end
      for (i = 0; i < motors; i++)
        push_result(ST_OK, i, level_copy[i], 0, 0, i == motors - 1);
    end else if (in_channel < first_ch || in_channel > LAST_CH) begin
      push_result(ST_BADCH, 0, 0, 0, 0, 1'b1);
    end else if (in_kind == KIND_ADD) begin
      for (i = 0; i < motors; i++) begin
        m = level_copy[i];
        level_copy[i] = clamp_level(m + mix_weight(layout_copy, i, ch) * u[ch]);
      end
      for (i = 0; i < motors; i++)
        push_result(ST_OK, i, level_copy[i], 0, 0, i == motors - 1);
    end else begin
      // Narrow the safe range over every motor that the channel moves.
      lo = LIMIT_NEG_UNBOUNDED;
      hi = LIMIT_POS_UNBOUNDED;
      for (i = 0; i < motors; i++) begin
        w = mix_weight(layout_copy, i, ch);
        m = level_copy[i];
        if (w > 0) begin
          if (FULL_LEVEL - m < hi) hi = FULL_LEVEL - m;
          if (-m > lo) lo = -m;
        end else if (w < 0) begin
          if (m < hi) hi = m;
          if (m - FULL_LEVEL > lo) lo = m - FULL_LEVEL;
        end
      end
      push_result(ST_OK, 0, 0, lo, hi, 1'b1);
    end
  endtask

  task automatic check_result();
    motor_result_t want;
    checked_total++;
    if (expected_results.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= 10)
        $display("unexpected result: status %0d motor %0d value %0d low %0d high %0d last %0d",
                 out_status, out_motor_index, out_motor_value, out_limit_low,
                 out_limit_high, out_last);
    end else begin
      want = expected_results.pop_front();
      if (out_status !== want.status || out_motor_index !== want.index ||
          out_motor_value !== want.value || out_limit_low !== want.low ||
          out_limit_high !== want.high || out_last !== want.last) begin
        mismatch_total++;
        if (mismatch_total <= 10) begin
          $display("mismatch on result %0d: expected status %0d motor %0d value %0d",
                   checked_total, want.status, want.index, want.value);
          $display("  low %0d high %0d last %0d; got status %0d motor %0d value %0d",
                   want.low, want.high, want.last, out_status, out_motor_index,
                   out_motor_value);
          $display("  low %0d high %0d last %0d", out_limit_low, out_limit_high, out_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      layout_copy = LAYOUT_NONE;
      for (int i = 0; i < MAX_MOTORS; i++) level_copy[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) layout_copy = cfg_data;
      if (out_strobe) check_result();
      if (start && !busy) predict_command();
    end
    pending_results <= expected_results.size();
    mismatches <= mismatch_total;
    results_checked <= checked_total;
  end

endmodule

`default_nettype wire

@@ sim/motor_mixer_with_saturation_unit_tb.sv @@
// Testbench top for the motor mixer: clock, reset, layout writes and command
// stimulus, with motor_result_checker beside the block giving the verdict data.
// Depends on mms_pkg, motor_mixer_with_saturation_unit and motor_result_checker.
`default_nettype none

module motor_mixer_with_saturation_unit_tb
  import mms_pkg::*;
();

  // The command kind that the block takes and ignores, and the layout code
  // that the block treats as not configured. Only the stimulus uses them.
  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  localparam logic [1:0] LAYOUT_UNKNOWN = 2'd3;

  // A healthy run never goes this many cycles without a transfer on either
  // side: the longest quiet stretch is an idle burst plus a settle pause.
  localparam int IDLE_LIMIT = 500;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [1:0]               cfg_data;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_kind;
  logic [2:0]               in_channel;
  logic signed [CTRL_W-1:0] in_ctrl_x;
  logic signed [CTRL_W-1:0] in_ctrl_y;
  logic signed [CTRL_W-1:0] in_ctrl_z;
  logic signed [CTRL_W-1:0] in_ctrl_roll;
  logic signed [CTRL_W-1:0] in_ctrl_pitch;
  logic signed [CTRL_W-1:0] in_ctrl_yaw;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic [3:0]               out_motor_index;
  logic [LEVEL_W-1:0]       out_motor_value;
  logic signed [CTRL_W-1:0] out_limit_low;
  logic signed [CTRL_W-1:0] out_limit_high;
  logic                     out_last;

  int mismatches;
  int pending_results;
  int results_checked;
  int idle_cycles = 0;
  int mix_sent = 0;
  int add_sent = 0;
  int check_sent = 0;
  int ignored_sent = 0;
  int layout_writes = 0;

  motor_mixer_with_saturation_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_ctrl_x       (in_ctrl_x),
    .in_ctrl_y       (in_ctrl_y),
    .in_ctrl_z       (in_ctrl_z),
    .in_ctrl_roll    (in_ctrl_roll),
    .in_ctrl_pitch   (in_ctrl_pitch),
    .in_ctrl_yaw     (in_ctrl_yaw),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_motor_index (out_motor_index),
    .out_motor_value (out_motor_value),
    .out_limit_low   (out_limit_low),
    .out_limit_high  (out_limit_high),
    .out_last        (out_last)
  );

  motor_result_checker result_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_ctrl_x       (in_ctrl_x),
    .in_ctrl_y       (in_ctrl_y),
    .in_ctrl_z       (in_ctrl_z),
    .in_ctrl_roll    (in_ctrl_roll),
    .in_ctrl_pitch   (in_ctrl_pitch),
    .in_ctrl_yaw     (in_ctrl_yaw),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_motor_index (out_motor_index),
    .out_motor_value (out_motor_value),
    .out_limit_low   (out_limit_low),
    .out_limit_high  (out_limit_high),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: counts cycles in which neither a command transfer nor a result
  // transfer happens, and stops a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // A control value drawn from the whole 17-bit range, with the extremes and
  // zero drawn often and a bias toward the span where motors are unsaturated.
  function automatic logic signed [CTRL_W-1:0] random_control();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return CTRL_W'(LIMIT_NEG_UNBOUNDED);
      1: return CTRL_W'(LIMIT_POS_UNBOUNDED);
      2: return '0;
      3, 4: return raw[CTRL_W-1:0];
      default: return CTRL_W'(int'($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  // Presents one command at the current rising edge and returns at the edge
  // where it transfers, that is, the first edge with start high and busy low.
  // start is left high so that a following command can go out back to back.
  task automatic send_command(input logic [1:0] kind, input logic [2:0] channel,
                              input int x, input int y, input int z,
                              input int roll, input int pitch, input int yaw);
    start <= 1'b1;
    in_kind <= kind;
    in_channel <= channel;
    in_ctrl_x <= CTRL_W'(x);
    in_ctrl_y <= CTRL_W'(y);
    in_ctrl_z <= CTRL_W'(z);
    in_ctrl_roll <= CTRL_W'(roll);
    in_ctrl_pitch <= CTRL_W'(pitch);
    in_ctrl_yaw <= CTRL_W'(yaw);
    do @(posedge clk); while (busy);
    case (kind)
      KIND_MIX: mix_sent++;
      KIND_ADD: add_sent++;
      KIND_CHECK: check_sent++;
      default: ignored_sent++;
    endcase
  endtask

  // Drops start and lets the block finish every result it owes before anything
  // else changes.
  task automatic wait_until_idle();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The layout register is only written while the block is idle.
  task automatic write_layout(input logic [1:0] layout);
    wait_until_idle();
    cfg_we <= 1'b1;
    cfg_data <= layout;
    @(posedge clk);
    cfg_we <= 1'b0;
    layout_writes++;
  endtask

  // Builds one random command for the current layout. Most commands use a
  // legal channel; add steps are mostly small so that motor levels wander
  // through the unsaturated range before they hit a rail. counted is low for
  // the unused kind, which the block merely drops.
  task automatic send_random_command(input logic [1:0] layout, output bit counted);
    logic [1:0]               kind;
    logic [2:0]               channel;
    logic signed [CTRL_W-1:0] ctrl [NUM_CONTROLS];
    int                       pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) kind = KIND_UNUSED;
    else if (pick < 34) kind = KIND_MIX;
    else if (pick < 70) kind = KIND_ADD;
    else kind = KIND_CHECK;
    if (layout != LAYOUT_DIRECT && layout != LAYOUT_AIRSHIP || $urandom_range(0, 9) == 0)
      channel = 3'($urandom_range(0, 7));
    else if (layout == LAYOUT_DIRECT)
      channel = 3'($urandom_range(DIRECT_MIN_CH, LAST_CH));
    else
      channel = 3'($urandom_range(AIRSHIP_MIN_CH, LAST_CH));
    for (int i = 0; i < NUM_CONTROLS; i++) ctrl[i] = random_control();
    if (kind == KIND_MIX && $urandom_range(0, 1) == 0) begin
      // Hover-like mix: negative throttle with modest attitude demands.
      ctrl[2] = CTRL_W'(-int'($urandom_range(0, 40000)));
      for (int i = 3; i < NUM_CONTROLS; i++)
        ctrl[i] = CTRL_W'(int'($urandom_range(0, 12000)) - 6000);
      ctrl[0] = CTRL_W'(int'($urandom_range(0, 40000)) - 8000);
    end
    if (kind == KIND_ADD && channel <= LAST_CH && $urandom_range(0, 9) < 7)
      ctrl[channel] = CTRL_W'(int'($urandom_range(0, 16000)) - 8000);
    send_command(kind, channel, ctrl[0], ctrl[1], ctrl[2], ctrl[3], ctrl[4], ctrl[5]);
    counted = (kind != KIND_UNUSED);
  endtask

  initial begin
    logic [1:0] layout_now;
    int         target;
    int         sent;
    bit         counted;
    bit         idling;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= LAYOUT_NONE;
    start <= 1'b0;
    in_kind <= KIND_MIX;
    in_channel <= '0;
    in_ctrl_x <= '0;
    in_ctrl_y <= '0;
    in_ctrl_z <= '0;
    in_ctrl_roll <= '0;
    in_ctrl_pitch <= '0;
    in_ctrl_yaw <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the layout is not configured, so every
    // command except the unused kind comes back as a single error result.
    send_command(KIND_MIX, 0, 1000, 0, -5000, 0, 0, 0);
    send_command(KIND_ADD, 3, 0, 0, 0, 4000, 0, 0);
    send_command(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0);

    // The spare layout code also acts as not configured.
    write_layout(LAYOUT_UNKNOWN);
    send_command(KIND_CHECK, 2, 0, 0, 0, 0, 0, 0);

    // Six-motor layout: channels below Z or above yaw are rejected, the channel field
    // of a mix is ignored, and levels clamp at both rails.
    write_layout(LAYOUT_DIRECT);
    send_command(KIND_MIX, 0, 0, 0, 0, 0, 0, 0);
    send_command(KIND_MIX, 7, 65535, -65536, -16384, 8000, -40000, 65535);
    send_command(KIND_CHECK, 3, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 2, 0, 0, -65536, 0, 0, 0);
    send_command(KIND_CHECK, 2, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 0, 5000, 0, 0, 0, 0, 0);
    send_command(KIND_CHECK, 1, 0, 5000, 0, 0, 0, 0);
    send_command(KIND_ADD, 6, 0, 0, 0, 0, 0, 0);
    send_command(KIND_CHECK, 7, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 5, 0, 0, 0, 0, 0, 65535);
    send_command(KIND_ADD, 4, 0, 0, 0, 0, -65536, 0);
    send_command(KIND_CHECK, 5, 0, 0, 0, 0, 0, 0);

    // Sixteen-motor layout keeps the levels left by the six-motor one. The Y
    // column is all zero, so its check reports unbounded limits.
    write_layout(LAYOUT_AIRSHIP);
    send_command(KIND_CHECK, 1, 0, 0, 0, 0, 0, 0);
    send_command(KIND_CHECK, 0, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 0, 20000, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 0, -65536, 0, 0, 0, 0, 0);
    send_command(KIND_MIX, 6, 65535, 65535, 65535, 65535, 65535, 65535);
    send_command(KIND_MIX, 0, -65536, -65536, -65536, -65536, -65536, -65536);
    send_command(KIND_MIX, 1, 12000, 0, -20000, 3000, -2000, 1000);
    send_command(KIND_CHECK, 4, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 3, 0, 0, 0, -5000, 0, 0);
    send_command(KIND_CHECK, 5, 0, 0, 0, 0, 0, 0);
    send_command(KIND_ADD, 7, 0, 0, 0, 0, 0, 0);

    // Random part, in phases with a layout each. The unconfigured phases are
    // short since they only ever produce error results. The final phase runs
    // without idle bursts so that commands go out back to back.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 4, 7, 9: layout_now = LAYOUT_DIRECT;
        2: layout_now = LAYOUT_NONE;
        5: layout_now = LAYOUT_UNKNOWN;
        default: layout_now = LAYOUT_AIRSHIP;
      endcase
      write_layout(layout_now);
      target = (layout_now == LAYOUT_NONE || layout_now == LAYOUT_UNKNOWN) ? 10 : 50;
      idling = (phase != 9);
      sent = 0;
      while (sent < target) begin
        if (idling && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        send_random_command(layout_now, counted);
        if (counted) sent++;
      end
    end

    // Drain: every expected result must arrive, then a short settle.
    wait_until_idle();
    repeat (20) @(posedge clk);

    $display("Sent %0d mix, %0d add, %0d check and %0d unused-kind commands",
             mix_sent, add_sent, check_sent, ignored_sent);
    $display("over %0d layout writes; %0d results compared, %0d mismatches, %0d missing.",
             layout_writes, results_checked, mismatches, pending_results);
    if (mismatches == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
